### hdl/uart_8n1_group_echo_defines.svh
// Assertion macros for the serial group echo block.
// Included by the top level; it depends on nothing else.
`ifndef UART_8N1_GROUP_ECHO_DEFINES_SVH
`define UART_8N1_GROUP_ECHO_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8GE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle check failed.");

// Next-cycle implication, checked outside reset.
`define U8GE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");

`endif

### hdl/u8ge_pkg.sv
// Shared types and register codes for the serial group echo block.
// Used by the core and the top level; it depends on nothing.
package u8ge_pkg;

  localparam int BIT_PERIOD_W = 16;
  localparam int BYTE_W = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_BIT_PERIOD = 1'b0;
  localparam logic REG_SEND_ORDER = 1'b1;

  localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST = 16'd6076;
  localparam logic SEND_MSB_FIRST_RST = 1'b1;

  typedef struct packed {
    logic [BIT_PERIOD_W-1:0] bit_period;
    logic                    send_msb_first;
  } cfg_t;

  typedef struct packed {
    logic              tx_level;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    logic              sending;
  } res_t;

endpackage

### hdl/u8ge_in_if.sv
// Input channel of the serial group echo block: one line sample per item.
// Depends on nothing.
interface u8ge_in_if;
  logic valid;
  logic ready;
  logic rx_level;

  modport source (output valid, output rx_level, input ready);
  modport sink (input valid, input rx_level, output ready);
endinterface

### hdl/u8ge_out_if.sv
// Result channel of the serial group echo block: one line result per item.
// Depends on nothing.
interface u8ge_out_if;
  logic       valid;
  logic       ready;
  logic       tx_level;
  logic [7:0] rx_byte;
  logic       rx_valid;
  logic       sending;

  modport source (output valid, output tx_level, output rx_byte, output rx_valid,
                  output sending, input ready);
  modport sink (input valid, input tx_level, input rx_byte, input rx_valid,
                input sending, output ready);
endinterface

### hdl/u8ge_core.sv
// Receive/send sequencer of the serial group echo block and its byte store.
// Depends on u8ge_pkg for the configuration and result types.
module u8ge_core import u8ge_pkg::*; #(
  parameter int GROUP_BYTES = 4,
  parameter int DATA_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic step,
  input  logic rx_level,
  output res_t res
);

  localparam int BIDX_W = $clog2(DATA_BITS + 2);
  localparam int SLOT_W = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
  localparam logic [BIDX_W-1:0] LAST_DATA = BIDX_W'(DATA_BITS);
  localparam logic [BIDX_W-1:0] STOP_IDX = BIDX_W'(DATA_BITS + 1);
  localparam logic [BIDX_W-1:0] TOP_POS = BIDX_W'(DATA_BITS - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(GROUP_BYTES - 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_SEND = 2'd2
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [BIT_PERIOD_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [BIDX_W-1:0]       bidx_r, bidx_nxt, bidx_dec, pos;
  logic [BYTE_W-1:0]       shift_r, shift_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [BYTE_W-1:0]       store_r [GROUP_BYTES];
  logic                    store_we;

  assign tick_inc = tick_r + BIT_PERIOD_W'(1);
  assign bidx_dec = bidx_r - BIDX_W'(1);
  assign pos = cfg.send_msb_first ? (TOP_POS - bidx_dec) : bidx_dec;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt = tick_r;
    bidx_nxt = bidx_r;
    shift_nxt = shift_r;
    slot_nxt = slot_r;
    store_we = 1'b0;
    res = '0;
    res.tx_level = 1'b1;
    unique case (phase_r)
      PH_SEND: begin
        res.sending = 1'b1;
        if (bidx_r == '0) begin
          res.tx_level = 1'b0;
        end else if (bidx_r > LAST_DATA) begin
          res.tx_level = 1'b1;
        end else if (int'(pos) < BYTE_W) begin
          res.tx_level = store_r[slot_r][pos[2:0]];
        end else begin
          res.tx_level = 1'b0;
        end
        tick_nxt = tick_inc;
        if (tick_inc >= cfg.bit_period) begin
          tick_nxt = '0;
          bidx_nxt = bidx_r + BIDX_W'(1);
          if (bidx_r == STOP_IDX) begin
            bidx_nxt = '0;
            slot_nxt = slot_r + SLOT_W'(1);
            if (slot_r == LAST_SLOT) begin
              slot_nxt = '0;
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      PH_RECV: begin
        tick_nxt = tick_inc;
        if (bidx_r == '0) begin
          if (tick_inc >= (cfg.bit_period >> 1)) begin
            tick_nxt = '0;
            bidx_nxt = BIDX_W'(1);
          end
        end else if (tick_inc >= cfg.bit_period) begin
          tick_nxt = '0;
          if (bidx_r <= LAST_DATA) begin
            if ((int'(bidx_dec) < BYTE_W) && rx_level) begin
              shift_nxt[bidx_dec[2:0]] = 1'b1;
            end
            bidx_nxt = bidx_r + BIDX_W'(1);
          end else begin
            res.rx_byte = shift_r;
            res.rx_valid = 1'b1;
            store_we = 1'b1;
            bidx_nxt = '0;
            slot_nxt = slot_r + SLOT_W'(1);
            phase_nxt = PH_IDLE;
            if (slot_r == LAST_SLOT) begin
              slot_nxt = '0;
              phase_nxt = PH_SEND;
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (!rx_level) begin
          phase_nxt = PH_RECV;
          tick_nxt = '0;
          bidx_nxt = '0;
          shift_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r <= '0;
      bidx_r <= '0;
      shift_r <= '0;
      slot_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r <= tick_nxt;
      bidx_r <= bidx_nxt;
      shift_r <= shift_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store_we) begin
      store_r[slot_r] <= shift_r;
    end
  end

endmodule

### hdl/uart_8n1_group_echo.sv
// Top level of the serial group echo block: channels, register port, pipeline.
// Depends on u8ge_pkg, u8ge_in_if, u8ge_out_if, u8ge_core and the defines header.
//
// Each input item is one clock tick of the receive line (rx_level). Each item
// gives exactly one result item: the transmit line level for that tick, the
// received byte with its strobe on the tick a byte completes at mid stop bit,
// and a flag that is high while the group of bytes is echoed back.
// An accepted item passes an input register and the sequencer logic into an
// output register, from which its result is offered. One item is taken every
// cycle while the receiver takes results; the rate is set by the single sequencer
// step per tick between the input and output registers. When the receiver stalls,
// the output register holds its result; an empty input register takes one more
// item, then ready falls; no item is lost. Reset (rst_n low at a clock edge)
// empties both registers, returns the sequencer to waiting for a start bit, sets
// bit_period to 6076 and the send order to most significant first. Registers are
// written over the APB port (bit_period at 0x0, send_msb_first at 0x4); the user
// must do so only while the block is idle, which the block does not enforce. The
// byte store holds no reset value and is only read after it is written.
`include "uart_8n1_group_echo_defines.svh"

module uart_8n1_group_echo import u8ge_pkg::*; #(
  parameter int GROUP_BYTES = 4,
  parameter int DATA_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  u8ge_in_if.sink            in_ch,
  u8ge_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg_r;
  logic in_vld_r, in_rx_r;
  logic out_vld_r;
  res_t out_res_r, res;
  logic adv, step, cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period <= BIT_PERIOD_RST;
      cfg_r.send_msb_first <= SEND_MSB_FIRST_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_BIT_PERIOD: cfg_r.bit_period <= pwdata[BIT_PERIOD_W-1:0];
        REG_SEND_ORDER: cfg_r.send_msb_first <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BIT_PERIOD: prdata = {{(PDATA_W-BIT_PERIOD_W){1'b0}}, cfg_r.bit_period};
      REG_SEND_ORDER: prdata = {{(PDATA_W-1){1'b0}}, cfg_r.send_msb_first};
    endcase
  end

  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || adv;
  assign step = in_vld_r && adv;

  u8ge_core #(
    .GROUP_BYTES(GROUP_BYTES),
    .DATA_BITS(DATA_BITS)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .step(step),
    .rx_level(in_rx_r),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      in_rx_r <= in_ch.rx_level;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.tx_level = out_res_r.tx_level;
  assign out_ch.rx_byte = out_res_r.rx_byte;
  assign out_ch.rx_valid = out_res_r.rx_valid;
  assign out_ch.sending = out_res_r.sending;

  `U8GE_ASSERT_NOW(a_no_rx_while_send, clk, rst_n, out_vld_r, !(out_res_r.rx_valid && out_res_r.sending))
  `U8GE_ASSERT_NOW(a_idle_line_high, clk, rst_n, out_vld_r && !out_res_r.sending, out_res_r.tx_level)
  `U8GE_ASSERT_NOW(a_byte_zero_no_strobe, clk, rst_n, out_vld_r && !out_res_r.rx_valid, out_res_r.rx_byte == '0)
  `U8GE_ASSERT_NEXT(a_stalled_item_kept, clk, rst_n, in_vld_r && !adv, in_vld_r)

endmodule
